// File: rtl/core/amsf_pkg.sv
// Shared types and codes for the actuator mode supervisor.
package amsf_pkg;

    // Supervisory modes.
    typedef enum logic [4:0] {
        M_DISCONNECTED = 5'd0,
        M_CONNECTED    = 5'd1,
        M_HW_CHECK     = 5'd2,
        M_MODE_SWITCH  = 5'd3,
        M_ENABLED      = 5'd4,
        M_PRE_CHECK    = 5'd5,
        M_HOMING       = 5'd6,
        M_TRAVEL_LEARN = 5'd7,
        M_MOTION_CHECK = 5'd8,
        M_READY        = 5'd9,
        M_CLAMPING     = 5'd10,
        M_UNLOADING    = 5'd11,
        M_RELEASING    = 5'd12,
        M_MANUAL_POS   = 5'd13,
        M_DISABLED     = 5'd14,
        M_ACTIVE_STOP  = 5'd15,
        M_FAULT        = 5'd16
    } t_mode;

    // Event codes; EV_NONE marks "no accepted event since reset".
    typedef enum logic [5:0] {
        EV_STOP_REQ       = 6'd0,
        EV_ASTOP_TRIG     = 6'd1,
        EV_FAULT_TRIG     = 6'd2,
        EV_DISCONNECT_REQ = 6'd3,
        EV_CONNECT_OK     = 6'd4,
        EV_HWCHK_REQ      = 6'd5,
        EV_MODESW_REQ     = 6'd6,
        EV_HWCHK_PASS     = 6'd7,
        EV_HWCHK_FAIL     = 6'd8,
        EV_ENABLE_OK      = 6'd9,
        EV_MODESW_FAIL    = 6'd10,
        EV_PRECHK_REQ     = 6'd11,
        EV_NUT_MOVE_REQ   = 6'd12,
        EV_HOMING_REQ     = 6'd13,
        EV_TRAVEL_REQ     = 6'd14,
        EV_MOTCHK_REQ     = 6'd15,
        EV_DISABLE_REQ    = 6'd16,
        EV_PRECHK_OK      = 6'd17,
        EV_PRECHK_FAIL    = 6'd18,
        EV_HOMING_OK      = 6'd19,
        EV_HOMING_FAIL    = 6'd20,
        EV_TRAVEL_OK      = 6'd21,
        EV_TRAVEL_FAIL    = 6'd22,
        EV_MOTCHK_OK      = 6'd23,
        EV_MOTCHK_FAIL    = 6'd24,
        EV_CLAMP_REQ      = 6'd25,
        EV_RELEASE_REQ    = 6'd26,
        EV_CLAMP_DONE     = 6'd27,
        EV_CLAMP_FAIL     = 6'd28,
        EV_DISABLE_DONE   = 6'd29,
        EV_RELEASE_DONE   = 6'd30,
        EV_RELEASE_FAIL   = 6'd31,
        EV_NUT_MOVE_DONE  = 6'd32,
        EV_NUT_MOVE_FAIL  = 6'd33,
        EV_FAULT_CLEARED  = 6'd34,
        EV_NONE           = 6'd35
    } t_event;

    // Decision codes on the result channel.
    localparam logic DEC_ACCEPT = 1'b0;
    localparam logic DEC_REJECT = 1'b1;

    // Outcome of one transition lookup.
    typedef struct packed {
        logic  accept;
        t_mode dest;
    } t_step;

endpackage

// File: rtl/core/amsf_next_mode.sv
// Transition table of the mode supervisor: next mode for a mode and an event.
module amsf_next_mode
    import amsf_pkg::*;
(
    input  t_mode        i_mode,
    input  logic [5:0]   i_event,
    output t_step        o_step
);

    t_event ev;

    assign ev = t_event'(i_event);

    always_comb begin
        o_step.accept = 1'b0;
        o_step.dest   = i_mode;
        case (ev)
            // forcing events, valid from any mode
            EV_FAULT_TRIG: begin
                o_step.accept = 1'b1;
                o_step.dest   = M_FAULT;
            end
            EV_STOP_REQ, EV_ASTOP_TRIG: begin
                o_step.accept = 1'b1;
                o_step.dest   = M_ACTIVE_STOP;
            end
            EV_DISCONNECT_REQ: begin
                o_step.accept = 1'b1;
                o_step.dest   = M_DISCONNECTED;
            end
            default: begin
                o_step.accept = 1'b1;
                case (i_mode)
                    M_DISCONNECTED: begin
                        case (ev)
                            EV_CONNECT_OK: o_step.dest   = M_CONNECTED;
                            default:       o_step.accept = 1'b0;
                        endcase
                    end
                    M_CONNECTED: begin
                        case (ev)
                            EV_HWCHK_REQ:  o_step.dest   = M_HW_CHECK;
                            EV_MODESW_REQ: o_step.dest   = M_MODE_SWITCH;
                            default:       o_step.accept = 1'b0;
                        endcase
                    end
                    M_HW_CHECK: begin
                        case (ev)
                            EV_HWCHK_PASS: o_step.dest   = M_MODE_SWITCH;
                            EV_HWCHK_FAIL: o_step.dest   = M_FAULT;
                            default:       o_step.accept = 1'b0;
                        endcase
                    end
                    M_MODE_SWITCH: begin
                        case (ev)
                            EV_ENABLE_OK:   o_step.dest   = M_ENABLED;
                            EV_MODESW_FAIL: o_step.dest   = M_FAULT;
                            default:        o_step.accept = 1'b0;
                        endcase
                    end
                    M_ENABLED: begin
                        case (ev)
                            EV_PRECHK_REQ:   o_step.dest   = M_PRE_CHECK;
                            EV_NUT_MOVE_REQ: o_step.dest   = M_MANUAL_POS;
                            EV_HOMING_REQ:   o_step.dest   = M_HOMING;
                            EV_TRAVEL_REQ:   o_step.dest   = M_TRAVEL_LEARN;
                            EV_MOTCHK_REQ:   o_step.dest   = M_MOTION_CHECK;
                            EV_DISABLE_REQ:  o_step.dest   = M_DISABLED;
                            default:         o_step.accept = 1'b0;
                        endcase
                    end
                    M_PRE_CHECK: begin
                        case (ev)
                            EV_PRECHK_OK:   o_step.dest   = M_ENABLED;
                            EV_PRECHK_FAIL: o_step.dest   = M_ACTIVE_STOP;
                            default:        o_step.accept = 1'b0;
                        endcase
                    end
                    M_HOMING: begin
                        case (ev)
                            EV_HOMING_OK:   o_step.dest   = M_ENABLED;
                            EV_HOMING_FAIL: o_step.dest   = M_FAULT;
                            default:        o_step.accept = 1'b0;
                        endcase
                    end
                    M_TRAVEL_LEARN: begin
                        case (ev)
                            EV_TRAVEL_OK:   o_step.dest   = M_ENABLED;
                            EV_TRAVEL_FAIL: o_step.dest   = M_FAULT;
                            default:        o_step.accept = 1'b0;
                        endcase
                    end
                    M_MOTION_CHECK: begin
                        case (ev)
                            EV_MOTCHK_OK:   o_step.dest   = M_READY;
                            EV_MOTCHK_FAIL: o_step.dest   = M_ACTIVE_STOP;
                            default:        o_step.accept = 1'b0;
                        endcase
                    end
                    M_READY: begin
                        case (ev)
                            EV_CLAMP_REQ:    o_step.dest   = M_CLAMPING;
                            EV_NUT_MOVE_REQ: o_step.dest   = M_MANUAL_POS;
                            EV_RELEASE_REQ:  o_step.dest   = M_RELEASING;
                            EV_DISABLE_REQ:  o_step.dest   = M_DISABLED;
                            default:         o_step.accept = 1'b0;
                        endcase
                    end
                    M_CLAMPING: begin
                        case (ev)
                            EV_CLAMP_DONE: o_step.dest   = M_UNLOADING;
                            EV_CLAMP_FAIL: o_step.dest   = M_ACTIVE_STOP;
                            default:       o_step.accept = 1'b0;
                        endcase
                    end
                    M_UNLOADING: begin
                        case (ev)
                            EV_DISABLE_DONE: o_step.dest   = M_DISABLED;
                            EV_RELEASE_DONE: o_step.dest   = M_READY;
                            default:         o_step.accept = 1'b0;
                        endcase
                    end
                    M_RELEASING: begin
                        case (ev)
                            EV_RELEASE_DONE: o_step.dest   = M_READY;
                            EV_RELEASE_FAIL: o_step.dest   = M_ACTIVE_STOP;
                            default:         o_step.accept = 1'b0;
                        endcase
                    end
                    M_MANUAL_POS: begin
                        case (ev)
                            EV_NUT_MOVE_DONE: o_step.dest   = M_UNLOADING;
                            EV_NUT_MOVE_FAIL: o_step.dest   = M_ACTIVE_STOP;
                            default:          o_step.accept = 1'b0;
                        endcase
                    end
                    M_DISABLED: begin
                        case (ev)
                            EV_ENABLE_OK: o_step.dest   = M_ENABLED;
                            default:      o_step.accept = 1'b0;
                        endcase
                    end
                    M_ACTIVE_STOP, M_FAULT: begin
                        case (ev)
                            EV_FAULT_CLEARED: o_step.dest   = M_DISABLED;
                            default:          o_step.accept = 1'b0;
                        endcase
                    end
                    default: o_step.accept = 1'b0;
                endcase
            end
        endcase
    end

endmodule

// File: rtl/core/actuator_mode_supervisor_fsm_core.sv
// Top level of the actuator mode supervisor: event register, mode state, result register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  event   | in        | i_valid / o_ready   | i_event_code[5:0]
//  result  | out       | o_valid / i_ready   | o_decision, o_mode_now[4:0], o_mode_before[4:0],
//          |           |                     | o_recorded_event[5:0], o_fault_flag, o_stop_flag
//
//  One event per clock in steady state while i_ready stays high; an event passes through the
//  event register, then one table lookup into the result register.
//  The mode state updates on the same edge that loads the result, so back-to-back events
//  each see the mode left by the one before.
//  Reset (synchronous, active low) puts the mode in disconnected, the recorded event at "none"
//  and empties both registers. A stall on i_ready holds the result and, once the event
//  register is full, drops o_ready in the same cycle.
module actuator_mode_supervisor_fsm_core
    import amsf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // event channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [5:0] i_event_code,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_decision,
    output logic [4:0] o_mode_now,
    output logic [4:0] o_mode_before,
    output logic [5:0] o_recorded_event,
    output logic       o_fault_flag,
    output logic       o_stop_flag
);

    // event register
    logic       r_in_valid;
    logic [5:0] r_event;

    // supervisor state
    t_mode      r_mode;
    t_mode      r_mode_before;
    logic [5:0] r_last_event;
    t_mode      n_mode;
    t_mode      n_mode_before;
    logic [5:0] n_last_event;
    logic       n_fault;
    logic       n_stop;

    // result register
    logic       r_out_valid;
    logic       r_decision;
    t_mode      r_out_mode;
    t_mode      r_out_before;
    logic [5:0] r_out_event;
    logic       r_out_fault;
    logic       r_out_stop;

    t_step      step;
    logic       advance;
    logic       take_in;

    // Move the held event into the result register when that slot is free or draining.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign take_in = i_valid && o_ready;

    amsf_next_mode u_next (
        .i_mode  (r_mode),
        .i_event (r_event),
        .o_step  (step)
    );

    // Next state: take the table's destination on an accepted event, else hold.
    always_comb begin
        n_mode        = r_mode;
        n_mode_before = r_mode_before;
        n_last_event  = r_last_event;
        if (advance && step.accept) begin
            n_mode        = step.dest;
            n_mode_before = r_mode;
            n_last_event  = r_event;
        end
    end

    // Outputs of the mode: flags follow the mode reported with the result.
    always_comb begin
        n_fault = (n_mode == M_FAULT);
        n_stop  = (n_mode == M_ACTIVE_STOP);
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_mode        <= M_DISCONNECTED;
            r_mode_before <= M_DISCONNECTED;
            r_last_event  <= EV_NONE;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            r_mode        <= n_mode;
            r_mode_before <= n_mode_before;
            r_last_event  <= n_last_event;
        end
    end

    // Payload registers: capture the event, load the result on advance.
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_event <= i_event_code;
        end
        if (advance) begin
            r_decision   <= step.accept ? DEC_ACCEPT : DEC_REJECT;
            r_out_mode   <= n_mode;
            r_out_before <= n_mode_before;
            r_out_event  <= n_last_event;
            r_out_fault  <= n_fault;
            r_out_stop   <= n_stop;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_decision       = r_decision;
    assign o_mode_now       = r_out_mode;
    assign o_mode_before    = r_out_before;
    assign o_recorded_event = r_out_event;
    assign o_fault_flag     = r_out_fault;
    assign o_stop_flag      = r_out_stop;

endmodule

// File: rtl/core/amsf_checker.sv
// Port-level checks for the actuator mode supervisor, bound to the top level.
module amsf_checker
    import amsf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_decision,
    input logic [4:0] o_mode_now,
    input logic [5:0] o_recorded_event,
    input logic       o_fault_flag,
    input logic       o_stop_flag
);

    // Fault and active stop never show together.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_fault_flag && o_stop_flag))
        else $error("fault and stop flags both set");

    // Fault flag tracks the fault mode.
    a_fault_matches_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fault_flag == (o_mode_now == M_FAULT)))
        else $error("fault flag disagrees with mode");

    // An accepted item always records a real event.
    a_accept_records: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_decision == DEC_ACCEPT) |-> (o_recorded_event != EV_NONE))
        else $error("accepted item without recorded event");

    // A just-accepted fault trigger lands in fault mode.
    a_fault_forces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_decision == DEC_ACCEPT && o_recorded_event == EV_FAULT_TRIG)
            |-> (o_mode_now == M_FAULT))
        else $error("fault trigger did not force fault mode");

    // A stalled result holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_mode_now)))
        else $error("result changed under stall");

endmodule

bind actuator_mode_supervisor_fsm_core amsf_checker u_amsf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_decision       (o_decision),
    .o_mode_now       (o_mode_now),
    .o_recorded_event (o_recorded_event),
    .o_fault_flag     (o_fault_flag),
    .o_stop_flag      (o_stop_flag)
);

// File: tb/sv/actuator_mode_supervisor_fsm_core_tb.sv
// Self-checking testbench for the actuator mode supervisor: directed walk, then random events.
module actuator_mode_supervisor_fsm_core_tb
    import amsf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS = 700;
    localparam int          CALM_FIRST   = 300;    // no idling on either side in this window
    localparam int          CALM_LAST    = 449;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          MAX_REPORTS  = 10;
    localparam int          DIR_ROWS     = 25;
    localparam logic [5:0]  EV_CODE_TOP  = 6'd63;  // highest code the field can carry
    localparam logic [5:0]  EV_CODE_ALT  = 6'd42;  // alternating bits, unknown code

    // Pinned expectation: decision and mode typed in from the table instead of predicted.
    typedef struct packed {
        bit    pinned;
        logic  dec;
        t_mode mode;
    } t_pin;

    typedef struct packed {
        logic [5:0] ev;
        t_pin       pin;
    } t_row;

    typedef struct packed {
        logic       dec;
        t_mode      mode_now;
        t_mode      mode_before;
        logic [5:0] rec_event;
        logic       fault;
        logic       stop;
    } t_result;

    localparam t_pin NO_PIN = '{1'b0, DEC_ACCEPT, M_DISCONNECTED};

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [5:0] i_event_code = '0;
    logic       i_ready      = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_decision;
    logic [4:0] o_mode_now;
    logic [4:0] o_mode_before;
    logic [5:0] o_recorded_event;
    logic       o_fault_flag;
    logic       o_stop_flag;

    actuator_mode_supervisor_fsm_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_event_code     (i_event_code),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_decision       (o_decision),
        .o_mode_now       (o_mode_now),
        .o_mode_before    (o_mode_before),
        .o_recorded_event (o_recorded_event),
        .o_fault_flag     (o_fault_flag),
        .o_stop_flag      (o_stop_flag)
    );

    always #6 i_clk = ~i_clk;

    // Directed walk: unknown codes and unlisted events first, then a tour through the
    // check, fault, stop and clamp paths, and finally every forcing event.
    t_row dir_rows [DIR_ROWS] = '{
        '{EV_CODE_TOP,       '{1'b1, DEC_REJECT, M_DISCONNECTED}},
        '{EV_NONE,           '{1'b1, DEC_REJECT, M_DISCONNECTED}},
        '{EV_TRAVEL_OK,      '{1'b1, DEC_REJECT, M_DISCONNECTED}},
        '{EV_CODE_ALT,       '{1'b1, DEC_REJECT, M_DISCONNECTED}},
        '{EV_CONNECT_OK,     '{1'b1, DEC_ACCEPT, M_CONNECTED}},
        '{EV_HWCHK_REQ,      NO_PIN},
        '{EV_HWCHK_FAIL,     '{1'b1, DEC_ACCEPT, M_FAULT}},
        '{EV_ENABLE_OK,      '{1'b1, DEC_REJECT, M_FAULT}},
        '{EV_FAULT_CLEARED,  NO_PIN},
        '{EV_ENABLE_OK,      NO_PIN},
        '{EV_PRECHK_REQ,     NO_PIN},
        '{EV_PRECHK_FAIL,    NO_PIN},
        '{EV_NUT_MOVE_REQ,   '{1'b1, DEC_REJECT, M_ACTIVE_STOP}},
        '{EV_FAULT_CLEARED,  NO_PIN},
        '{EV_ENABLE_OK,      NO_PIN},
        '{EV_MOTCHK_REQ,     NO_PIN},
        '{EV_MOTCHK_OK,      NO_PIN},
        '{EV_CLAMP_REQ,      NO_PIN},
        '{EV_CLAMP_DONE,     NO_PIN},
        '{EV_RELEASE_DONE,   NO_PIN},
        '{EV_STOP_REQ,       '{1'b1, DEC_ACCEPT, M_ACTIVE_STOP}},
        '{EV_DISCONNECT_REQ, '{1'b1, DEC_ACCEPT, M_DISCONNECTED}},
        '{EV_ASTOP_TRIG,     '{1'b1, DEC_ACCEPT, M_ACTIVE_STOP}},
        '{EV_FAULT_TRIG,     '{1'b1, DEC_ACCEPT, M_FAULT}},
        '{EV_DISCONNECT_REQ, '{1'b1, DEC_ACCEPT, M_DISCONNECTED}}
    };

    // Mode the supervisor would move to on this event; returns 0 when the event is rejected.
    function automatic bit mode_transition(input t_mode m, input logic [5:0] ev,
                                           output t_mode dest);
        bit hit;
        hit  = 1'b1;
        dest = m;
        case (ev)
            EV_FAULT_TRIG:              dest = M_FAULT;
            EV_STOP_REQ, EV_ASTOP_TRIG: dest = M_ACTIVE_STOP;
            EV_DISCONNECT_REQ:          dest = M_DISCONNECTED;
            default: begin
                case ({m, ev})
                    {M_DISCONNECTED, EV_CONNECT_OK}:    dest = M_CONNECTED;
                    {M_CONNECTED,    EV_HWCHK_REQ}:     dest = M_HW_CHECK;
                    {M_CONNECTED,    EV_MODESW_REQ}:    dest = M_MODE_SWITCH;
                    {M_HW_CHECK,     EV_HWCHK_PASS}:    dest = M_MODE_SWITCH;
                    {M_HW_CHECK,     EV_HWCHK_FAIL}:    dest = M_FAULT;
                    {M_MODE_SWITCH,  EV_ENABLE_OK}:     dest = M_ENABLED;
                    {M_MODE_SWITCH,  EV_MODESW_FAIL}:   dest = M_FAULT;
                    {M_ENABLED,      EV_PRECHK_REQ}:    dest = M_PRE_CHECK;
                    {M_ENABLED,      EV_NUT_MOVE_REQ}:  dest = M_MANUAL_POS;
                    {M_ENABLED,      EV_HOMING_REQ}:    dest = M_HOMING;
                    {M_ENABLED,      EV_TRAVEL_REQ}:    dest = M_TRAVEL_LEARN;
                    {M_ENABLED,      EV_MOTCHK_REQ}:    dest = M_MOTION_CHECK;
                    {M_ENABLED,      EV_DISABLE_REQ}:   dest = M_DISABLED;
                    {M_PRE_CHECK,    EV_PRECHK_OK}:     dest = M_ENABLED;
                    {M_PRE_CHECK,    EV_PRECHK_FAIL}:   dest = M_ACTIVE_STOP;
                    {M_HOMING,       EV_HOMING_OK}:     dest = M_ENABLED;
                    {M_HOMING,       EV_HOMING_FAIL}:   dest = M_FAULT;
                    {M_TRAVEL_LEARN, EV_TRAVEL_OK}:     dest = M_ENABLED;
                    {M_TRAVEL_LEARN, EV_TRAVEL_FAIL}:   dest = M_FAULT;
                    {M_MOTION_CHECK, EV_MOTCHK_OK}:     dest = M_READY;
                    {M_MOTION_CHECK, EV_MOTCHK_FAIL}:   dest = M_ACTIVE_STOP;
                    {M_READY,        EV_CLAMP_REQ}:     dest = M_CLAMPING;
                    {M_READY,        EV_NUT_MOVE_REQ}:  dest = M_MANUAL_POS;
                    {M_READY,        EV_RELEASE_REQ}:   dest = M_RELEASING;
                    {M_READY,        EV_DISABLE_REQ}:   dest = M_DISABLED;
                    {M_CLAMPING,     EV_CLAMP_DONE}:    dest = M_UNLOADING;
                    {M_CLAMPING,     EV_CLAMP_FAIL}:    dest = M_ACTIVE_STOP;
                    {M_UNLOADING,    EV_DISABLE_DONE}:  dest = M_DISABLED;
                    {M_UNLOADING,    EV_RELEASE_DONE}:  dest = M_READY;
                    {M_RELEASING,    EV_RELEASE_DONE}:  dest = M_READY;
                    {M_RELEASING,    EV_RELEASE_FAIL}:  dest = M_ACTIVE_STOP;
                    {M_MANUAL_POS,   EV_NUT_MOVE_DONE}: dest = M_UNLOADING;
                    {M_MANUAL_POS,   EV_NUT_MOVE_FAIL}: dest = M_ACTIVE_STOP;
                    {M_DISABLED,     EV_ENABLE_OK}:     dest = M_ENABLED;
                    {M_ACTIVE_STOP,  EV_FAULT_CLEARED}: dest = M_DISABLED;
                    {M_FAULT,        EV_FAULT_CLEARED}: dest = M_DISABLED;
                    default:                            hit  = 1'b0;
                endcase
            end
        endcase
        return hit;
    endfunction

    // Favor events the current mode lists so the walk gets deep; mix in forcing
    // events, any defined code, and any code the field can carry.
    function automatic logic [5:0] pick_event(input t_mode m);
        logic [5:0] listed [$];
        t_mode      dest;
        int         roll;
        int         c;
        roll = $urandom_range(99);
        if (roll < 68) begin
            for (c = EV_CONNECT_OK; c <= EV_FAULT_CLEARED; c++)
                if (mode_transition(m, 6'(c), dest))
                    listed.push_back(6'(c));
            return listed[$urandom_range(listed.size() - 1)];
        end
        if (roll < 78)
            return 6'($urandom_range(EV_DISCONNECT_REQ, EV_STOP_REQ));
        if (roll < 90)
            return 6'($urandom_range(EV_FAULT_CLEARED));
        return 6'($urandom_range(EV_CODE_TOP));
    endfunction

    // Supervisor copy kept in step with accepted events.
    t_mode      sv_mode      = M_DISCONNECTED;
    t_mode      sv_prior     = M_DISCONNECTED;
    logic [5:0] sv_last_ev   = EV_NONE;
    logic       sv_fault     = 1'b0;
    logic       sv_stop      = 1'b0;

    t_mode      plan_mode    = M_DISCONNECTED;  // mode seen by the stimulus side
    t_result    expected_results [$];
    t_pin       pinned_results   [$];
    bit         ev_fire      = 1'b0;
    bit         calm         = 1'b0;
    int         cycle_cnt    = 0;
    int         err_cnt      = 0;
    int         n_accepted   = 0;
    int         n_rejected   = 0;
    logic [16:0] modes_seen  = 17'd1;

    // Stall the result side at random, with about a 15 percent chance, except inside the calm window.
    always @(negedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 15);
    end

    always @(posedge i_clk) begin : monitor
        t_mode   dest;
        t_pin    pin;
        t_result want;
        t_result got;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_results.size());
            $display("actuator_mode_supervisor_fsm_core verification failed");
            $finish;
        end
        if (!i_rst_n) begin
            ev_fire <= 1'b0;
        end else begin
            ev_fire <= i_valid && o_ready;

            // Check the result side against the oldest expectation.
            if (o_valid && i_ready) begin
                got = '{o_decision, t_mode'(o_mode_now), t_mode'(o_mode_before),
                        o_recorded_event, o_fault_flag, o_stop_flag};
                if (expected_results.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("[%0t] result with nothing expected: dec=%0d now=%0d",
                                 $realtime, got.dec, got.mode_now);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS) begin
                            $display("[%0t] mismatch dec/now/before/ev/fault/stop",
                                     $realtime);
                            $display("    exp %0d/%0d/%0d/%0d/%0d/%0d",
                                     want.dec, want.mode_now, want.mode_before,
                                     want.rec_event, want.fault, want.stop);
                            $display("    got %0d/%0d/%0d/%0d/%0d/%0d",
                                     got.dec, got.mode_now, got.mode_before,
                                     got.rec_event, got.fault, got.stop);
                        end
                    end
                end
            end

            // Advance the supervisor copy on each accepted event.
            if (i_valid && o_ready) begin
                pin = pinned_results.pop_front();
                if (mode_transition(sv_mode, i_event_code, dest)) begin
                    sv_prior   = sv_mode;
                    sv_mode    = dest;
                    sv_last_ev = i_event_code;
                    sv_fault   = (dest == M_FAULT);
                    sv_stop    = (dest == M_ACTIVE_STOP);
                    want.dec   = DEC_ACCEPT;
                    n_accepted++;
                    modes_seen[dest] = 1'b1;
                end else begin
                    want.dec   = DEC_REJECT;
                    n_rejected++;
                end
                want.mode_now    = sv_mode;
                want.mode_before = sv_prior;
                want.rec_event   = sv_last_ev;
                want.fault       = sv_fault;
                want.stop        = sv_stop;
                // Typed-in values take the place of the predicted ones.
                if (pin.pinned) begin
                    want.dec      = pin.dec;
                    want.mode_now = pin.mode;
                end
                expected_results.push_back(want);
            end
        end
    end

    // Present one event at a falling edge and hold it until the handshake completes.
    task automatic send_event(input logic [5:0] ev, input t_pin pin);
        t_mode dest;
        int    gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(99) < 15)
                gap++;
        if (mode_transition(plan_mode, ev, dest))
            plan_mode = dest;
        pinned_results.push_back(pin);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_event_code <= ev;
        do
            @(negedge i_clk);
        while (!ev_fire);
    endtask

    initial begin
        int k;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (k = 0; k < DIR_ROWS; k++)
            send_event(dir_rows[k].ev, dir_rows[k].pin);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            calm <= (k >= CALM_FIRST) && (k <= CALM_LAST);
            send_event(pick_event(plan_mode), NO_PIN);
        end
        i_valid <= 1'b0;
        calm    <= 1'b0;

        // Drain, then give the two-stage pipe time to show any stray result.
        while (expected_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("%0d events taken (%0d accepted, %0d rejected) in %0d cycles",
                 n_accepted + n_rejected, n_accepted, n_rejected, cycle_cnt);
        $display("%0d of 17 modes reached, %0d mismatches", $countones(modes_seen), err_cnt);
        if (err_cnt == 0) begin
            $display("actuator_mode_supervisor_fsm_core verification clean");
        end else begin
            $display("actuator_mode_supervisor_fsm_core verification failed");
        end
        $finish;
    end

endmodule

// File: actuator_mode_supervisor_fsm_core.f
rtl/core/amsf_pkg.sv
rtl/core/amsf_next_mode.sv
rtl/core/actuator_mode_supervisor_fsm_core.sv
rtl/core/amsf_checker.sv
tb/sv/actuator_mode_supervisor_fsm_core_tb.sv
